### rtl/core/mmeu_pkg.sv
package mmeu_pkg;

   localparam int LIMB_W    = 64;
   localparam int WORD_W    = 32;
   localparam int MOD_BITS  = 120;
   localparam int HI_W      = MOD_BITS - LIMB_W;
   localparam int OP_W      = 2 * LIMB_W;
   // Two partial product rounds never push the accumulator past 2^194.
   localparam int ACC_W     = OP_W + LIMB_W + 2;
   localparam int EXP_BITS  = 64;
   localparam int BIT_CNT_W = $clog2(EXP_BITS);
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 3;
   localparam int OFF_W     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MOD_LO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_HI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NINV   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_R2_LO  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_R2_HI  = 3'd4;

   localparam logic [1:0] ASEL_X   = 2'd0;
   localparam logic [1:0] ASEL_Y   = 2'd1;
   localparam logic [1:0] ASEL_ONE = 2'd2;

   localparam logic [1:0] BSEL_X   = 2'd0;
   localparam logic [1:0] BSEL_R2  = 2'd1;
   localparam logic [1:0] BSEL_ONE = 2'd2;

   localparam logic DEST_X = 1'b0;
   localparam logic DEST_Y = 1'b1;

   localparam logic [1:0] MAC_AB = 2'd0;
   localparam logic [1:0] MAC_M  = 2'd1;
   localparam logic [1:0] MAC_MP = 2'd2;

   typedef struct packed {
      logic              capture;
      logic              load;
      logic [1:0]        a_sel;
      logic [1:0]        b_sel;
      logic              issue;
      logic [1:0]        phase;
      logic [STEP_W-1:0] step;
      logic              round;
      logic              shift;
      logic              finish;
      logic              dest;
      logic              deliver;
   } dp_cmd_type;

endpackage

### rtl/core/montgomery_modular_exponentiation_unit.sv
// One request is worked on at a time.
// Each Montgomery product runs on the single shared 32x32 multiplier.
// busy is high from the cycle after a request is taken until the result strobe.
// Synchronous active-high reset sets the modulus to one and clears the CSRs and the FSM.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per request.
module montgomery_modular_exponentiation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_base_lo,
   input  logic [55:0] req_base_hi,
   input  logic [63:0] req_exponent,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_lo,
   output logic [55:0] rsp_result_hi,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import mmeu_pkg::*;

   dp_cmd_type cmd;

   mmeu_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_exponent (req_exponent),
      .busy         (busy),
      .cmd          (cmd)
   );

   mmeu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_base_lo      (req_base_lo),
      .req_base_hi      (req_base_hi),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_result_lo    (rsp_result_lo),
      .rsp_result_hi    (rsp_result_hi)
   );

endmodule

### rtl/core/mmeu_datapath.sv
module mmeu_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  mmeu_pkg::dp_cmd_type      cmd,
   input  logic [63:0]               req_base_lo,
   input  logic [55:0]               req_base_hi,
   input  logic                      csr_write_enable,
   input  logic [2:0]                csr_index,
   input  logic [63:0]               csr_write_data,
   output logic                      rsp_valid,
   output logic [63:0]               rsp_result_lo,
   output logic [55:0]               rsp_result_hi
);
   import mmeu_pkg::*;

   logic [LIMB_W-1:0] mod_lo_ff, mod_lo_in;
   logic [HI_W-1:0]   mod_hi_ff, mod_hi_in;
   logic [LIMB_W-1:0] ninv_ff, ninv_in;
   logic [LIMB_W-1:0] r2_lo_ff, r2_lo_in;
   logic [HI_W-1:0]   r2_hi_ff, r2_hi_in;

   logic [OP_W-1:0]   x_ff, x_in;
   logic [OP_W-1:0]   y_ff, y_in;
   logic [OP_W-1:0]   op_a_ff, op_a_in;
   logic [OP_W-1:0]   op_b_ff, op_b_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [LIMB_W-1:0] m_ff, m_in;

   logic [2*WORD_W-1:0] prod_ff, prod_in;
   logic                pv_ff, pv_in;
   logic                ptgt_m_ff, ptgt_m_in;
   logic [OFF_W-1:0]    poff_ff, poff_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LIMB_W-1:0]   res_lo_ff, res_lo_in;
   logic [HI_W-1:0]     res_hi_ff, res_hi_in;

   logic [OP_W-1:0]   p_full;
   logic [LIMB_W-1:0] a_limb;
   logic [WORD_W-1:0] mul_x, mul_y;
   logic              mul_tgt_m;
   logic [OFF_W-1:0]  mul_off;
   logic [OP_W+1:0]   fin_t, fin_p, fin_r;

   assign p_full = OP_W'({mod_hi_ff, mod_lo_ff});
   assign a_limb = cmd.round ? op_a_ff[OP_W-1:LIMB_W] : op_a_ff[LIMB_W-1:0];

   always_comb begin
      mul_x     = '0;
      mul_y     = '0;
      mul_tgt_m = 1'b0;
      mul_off   = '0;
      unique case (cmd.phase)
         MAC_AB: begin
            mul_x   = a_limb[WORD_W*cmd.step[2] +: WORD_W];
            mul_y   = op_b_ff[WORD_W*cmd.step[1:0] +: WORD_W];
            mul_off = OFF_W'(cmd.step[2]) + OFF_W'(cmd.step[1:0]);
         end
         MAC_M: begin
            mul_tgt_m = 1'b1;
            unique case (cmd.step[1:0])
               2'd0: begin
                  mul_x = acc_ff[WORD_W-1:0];
                  mul_y = ninv_ff[WORD_W-1:0];
               end
               2'd1: begin
                  mul_x   = acc_ff[WORD_W-1:0];
                  mul_y   = ninv_ff[LIMB_W-1:WORD_W];
                  mul_off = OFF_W'(1);
               end
               default: begin
                  mul_x   = acc_ff[LIMB_W-1:WORD_W];
                  mul_y   = ninv_ff[WORD_W-1:0];
                  mul_off = OFF_W'(1);
               end
            endcase
         end
         MAC_MP: begin
            mul_x   = m_ff[WORD_W*cmd.step[2] +: WORD_W];
            mul_y   = p_full[WORD_W*cmd.step[1:0] +: WORD_W];
            mul_off = OFF_W'(cmd.step[2]) + OFF_W'(cmd.step[1:0]);
         end
         default: begin
            mul_x = '0;
         end
      endcase
   end

   assign prod_in   = mul_x * mul_y;
   assign pv_in     = cmd.issue;
   assign ptgt_m_in = mul_tgt_m;
   assign poff_in   = mul_off;

   assign fin_t = acc_ff[OP_W+1:0];
   assign fin_p = (OP_W+2)'(p_full);
   assign fin_r = (fin_t >= fin_p) ? fin_t - fin_p : fin_t;

   always_comb begin
      mod_lo_in = mod_lo_ff;
      mod_hi_in = mod_hi_ff;
      ninv_in   = ninv_ff;
      r2_lo_in  = r2_lo_ff;
      r2_hi_in  = r2_hi_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MOD_LO: mod_lo_in = csr_write_data;
            CSR_MOD_HI: mod_hi_in = csr_write_data[HI_W-1:0];
            CSR_NINV:   ninv_in   = csr_write_data;
            CSR_R2_LO:  r2_lo_in  = csr_write_data;
            CSR_R2_HI:  r2_hi_in  = csr_write_data[HI_W-1:0];
            default:    mod_lo_in = mod_lo_ff;
         endcase
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      op_a_in = op_a_ff;
      op_b_in = op_b_ff;
      acc_in  = acc_ff;
      m_in    = m_ff;
      if (cmd.capture) begin
         x_in = OP_W'({req_base_hi, req_base_lo});
      end
      if (cmd.load) begin
         unique case (cmd.a_sel)
            ASEL_X:   op_a_in = x_ff;
            ASEL_Y:   op_a_in = y_ff;
            default:  op_a_in = OP_W'(1);
         endcase
         unique case (cmd.b_sel)
            BSEL_X:   op_b_in = x_ff;
            BSEL_R2:  op_b_in = OP_W'({r2_hi_ff, r2_lo_ff});
            default:  op_b_in = OP_W'(1);
         endcase
         acc_in = '0;
         m_in   = '0;
      end else if (cmd.shift) begin
         acc_in = acc_ff >> LIMB_W;
         m_in   = '0;
      end else if (pv_ff) begin
         if (ptgt_m_ff) begin
            m_in = m_ff + LIMB_W'({prod_ff, 5'b0} << (WORD_W - 32 + 32 * poff_ff[0]) >> 5);
         end else begin
            acc_in = acc_ff + (ACC_W'(prod_ff) << {poff_ff, 5'b0});
         end
      end
      if (cmd.finish) begin
         if (cmd.dest == DEST_Y) begin
            y_in = fin_r[OP_W-1:0];
         end else begin
            x_in = fin_r[OP_W-1:0];
         end
      end
   end

   assign rsp_valid_in = cmd.deliver;
   assign res_lo_in    = cmd.deliver ? y_ff[LIMB_W-1:0] : res_lo_ff;
   assign res_hi_in    = cmd.deliver ? y_ff[LIMB_W+HI_W-1:LIMB_W] : res_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_lo_ff    <= LIMB_W'(1);
         mod_hi_ff    <= '0;
         ninv_ff      <= '0;
         r2_lo_ff     <= '0;
         r2_hi_ff     <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_lo_ff    <= mod_lo_in;
         mod_hi_ff    <= mod_hi_in;
         ninv_ff      <= ninv_in;
         r2_lo_ff     <= r2_lo_in;
         r2_hi_ff     <= r2_hi_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      op_a_ff   <= op_a_in;
      op_b_ff   <= op_b_in;
      acc_ff    <= acc_in;
      m_ff      <= m_in;
      prod_ff   <= prod_in;
      ptgt_m_ff <= ptgt_m_in;
      poff_ff   <= poff_in;
      res_lo_ff <= res_lo_in;
      res_hi_ff <= res_hi_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_lo = res_lo_ff;
   assign rsp_result_hi = res_hi_ff;

`ifndef SYNTHESIS
   a_acc_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (acc_ff[ACC_W-1:OP_W+2] == '0))
      else $error("accumulator exceeds its bound at the final subtraction");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");
   a_strobe_follows_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.deliver))
      else $error("result strobe without a deliver command");
`endif

endmodule

### rtl/core/mmeu_controller.sv
module mmeu_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            req_exponent,
   output logic                   busy,
   output mmeu_pkg::dp_cmd_type   cmd
);
   import mmeu_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_AB     = 3'd2;
   localparam logic [2:0] S_M      = 3'd3;
   localparam logic [2:0] S_MP     = 3'd4;
   localparam logic [2:0] S_SHIFT  = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   localparam logic [2:0] K_BASE = 3'd0;
   localparam logic [2:0] K_ONE  = 3'd1;
   localparam logic [2:0] K_MUL  = 3'd2;
   localparam logic [2:0] K_SQR  = 3'd3;
   localparam logic [2:0] K_OUT  = 3'd4;

   localparam logic [3:0] AB_STEPS = 4'd8;
   localparam logic [3:0] M_STEPS  = 4'd3;
   localparam logic [3:0] MP_STEPS = 4'd8;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           kind_ff, kind_in;
   logic [3:0]           step_ff, step_in;
   logic                 round_ff, round_in;
   logic [EXP_BITS-1:0]  exp_ff, exp_in;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic                 accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.step     = step_ff[STEP_W-1:0];
      cmd.round    = round_ff;
      state_in     = state_ff;
      kind_in      = kind_ff;
      step_in      = step_ff;
      round_in     = round_ff;
      exp_in       = exp_ff;
      bit_in       = bit_ff;

      unique case (kind_ff)
         K_BASE: begin cmd.a_sel = ASEL_X;   cmd.b_sel = BSEL_R2;  cmd.dest = DEST_X; end
         K_ONE:  begin cmd.a_sel = ASEL_ONE; cmd.b_sel = BSEL_R2;  cmd.dest = DEST_Y; end
         K_MUL:  begin cmd.a_sel = ASEL_Y;   cmd.b_sel = BSEL_X;   cmd.dest = DEST_Y; end
         K_SQR:  begin cmd.a_sel = ASEL_X;   cmd.b_sel = BSEL_X;   cmd.dest = DEST_X; end
         default: begin cmd.a_sel = ASEL_Y;  cmd.b_sel = BSEL_ONE; cmd.dest = DEST_Y; end
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               exp_in      = req_exponent[EXP_BITS-1:0];
               bit_in      = '0;
               kind_in     = K_BASE;
               state_in    = S_START;
            end
         end
         S_START: begin
            cmd.load = 1'b1;
            round_in = 1'b0;
            step_in  = '0;
            state_in = S_AB;
         end
         S_AB: begin
            cmd.phase = MAC_AB;
            cmd.issue = (step_ff != AB_STEPS);
            if (step_ff == AB_STEPS) begin
               step_in  = '0;
               state_in = S_M;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_M: begin
            cmd.phase = MAC_M;
            cmd.issue = (step_ff != M_STEPS);
            if (step_ff == M_STEPS) begin
               step_in  = '0;
               state_in = S_MP;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_MP: begin
            cmd.phase = MAC_MP;
            cmd.issue = (step_ff != MP_STEPS);
            if (step_ff == MP_STEPS) begin
               step_in  = '0;
               state_in = S_SHIFT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (round_ff) begin
               state_in = S_FINISH;
            end else begin
               round_in = 1'b1;
               state_in = S_AB;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_START;
            unique case (kind_ff)
               K_BASE: kind_in = K_ONE;
               K_ONE:  kind_in = exp_ff[0] ? K_MUL : K_SQR;
               K_MUL:  kind_in = K_SQR;
               K_SQR: begin
                  exp_in = exp_ff >> 1;
                  bit_in = bit_ff + BIT_CNT_W'(1);
                  if (bit_ff == BIT_CNT_W'(EXP_BITS - 1)) begin
                     kind_in = K_OUT;
                  end else begin
                     kind_in = exp_ff[1] ? K_MUL : K_SQR;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         default: begin
            cmd.deliver = 1'b1;
            state_in    = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= K_BASE;
         step_ff  <= '0;
         round_ff <= 1'b0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         step_ff  <= step_in;
         round_ff <= round_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
   end

`ifndef SYNTHESIS
   a_issue_in_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (state_ff == S_AB || state_ff == S_M || state_ff == S_MP))
      else $error("multiplier issued outside a multiply phase");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && state_ff == S_START && kind_ff == K_BASE))
      else $error("accepted request did not start the base conversion");
   a_done_from_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> $past(state_ff == S_FINISH && kind_ff == K_OUT))
      else $error("result delivered without the final conversion");
`endif

endmodule
